>>> rtl/lzwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lzwd_pkg;

	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int START_POS       = 4078;
	localparam logic [7:0] FILL_BYTE   = 8'h20;
	localparam logic [7:0] FLAG_FILL   = 8'hff;
	localparam logic [4:0] MATCH_BIAS  = 5'd3;

	typedef enum logic [1:0] {
		PH_FLAG   = 2'd0,
		PH_TOKEN  = 2'd1,
		PH_MATCH2 = 2'd2
	} phase_t;

	// where the byte held in the data stage comes from
	typedef enum logic [1:0] {
		SRC_RAM  = 2'd0,
		SRC_HELD = 2'd1,
		SRC_FILL = 2'd2
	} src_t;

	typedef struct packed {
		logic lit_load;
		logic cp_start;
		logic cut_rst;
	} tok_ctl_t;

endpackage
`default_nettype wire

>>> rtl/lzss_window_decoder_unit.sv
// Path: a literal is held in the data stage, then in the output register that drives out_byte;
// match bytes are read from the window into the data stage, then pass the output register,
// one byte a cycle while out_stall does not hold the output. Requests stall until a match is
// copied, as the window memory has a single read port (one byte read per cycle).
// Reset: arst_n clears all control state; window contents need no clearing pass, since a
// fill count marks entries not yet written in this stream, and those read as spaces.
`timescale 1ns / 1ps
`default_nettype none
module lzss_window_decoder_unit #(
	parameter int WINDOW_SIZE = lzwd_pkg::WINDOW_SIZE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] out_byte,
	output      logic       out_last
);
	import lzwd_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam logic [AW-1:0] START_AD = AW'(START_POS);
	localparam logic [AW:0]   FILL_MAX = (AW+1)'(WINDOW_SIZE);

	logic [7:0] win_mem [WINDOW_SIZE];

	phase_t     phase_q, phase_d;
	logic [15:0] flag_q, flag_d;
	logic [7:0] first_q, first_d;
	tok_ctl_t   ctl;

	logic [AW-1:0] wp_q;
	logic [AW:0]   fill_q;
	logic [AW-1:0] cp_addr_q;
	logic [4:0]    cp_cnt_q;
	logic          cp_last_q;

	logic       vld_s1;
	src_t       src_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic [7:0] rd_data_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic          acc;
	logic          s1_adv;
	logic          slot_free;
	logic          rd_en;
	logic          hit;
	logic          filled;
	logic [AW-1:0] rel_ad;
	logic [7:0]    s1_data;
	logic [15:0]   flag_sh;

	assign s1_adv    = vld_s1 && (!out_valid_q || !out_stall);
	assign slot_free = !vld_s1 || s1_adv;
	assign in_stall  = (cp_cnt_q != 5'd0) || !slot_free;
	assign acc       = in_valid && !in_stall;
	assign rd_en     = (cp_cnt_q != 5'd0) && slot_free;
	assign hit       = s1_adv && (cp_addr_q == wp_q);
	assign rel_ad    = cp_addr_q - START_AD;
	assign filled    = {1'b0, rel_ad} < fill_q;
	assign flag_sh   = flag_q >> 1;

	always_comb begin
		case (src_s1)
			SRC_RAM:  s1_data = rd_data_s1;
			SRC_HELD: s1_data = byte_s1;
			SRC_FILL: s1_data = FILL_BYTE;
			default:  s1_data = FILL_BYTE;
		endcase
	end

	// token parser: next state
	always_comb begin
		phase_d = phase_q;
		flag_d  = flag_q;
		first_d = first_q;
		if (acc) begin
			case (phase_q)
				PH_TOKEN: begin
					if (flag_q[0]) begin
						flag_d  = flag_sh;
						phase_d = flag_sh[8] ? PH_TOKEN : PH_FLAG;
					end else begin
						first_d = data_byte;
						phase_d = PH_MATCH2;
					end
				end
				PH_MATCH2: begin
					flag_d  = flag_sh;
					phase_d = flag_sh[8] ? PH_TOKEN : PH_FLAG;
				end
				default: begin
					flag_d  = {FLAG_FILL, data_byte};
					phase_d = PH_TOKEN;
				end
			endcase
			if (last_byte) begin
				flag_d  = '0;
				first_d = '0;
				phase_d = PH_FLAG;
			end
		end
	end

	// token parser: outputs
	always_comb begin
		ctl = '0;
		case (phase_q)
			PH_TOKEN:  ctl.lit_load = acc && flag_q[0];
			PH_MATCH2: ctl.cp_start = acc;
			default:   ctl.lit_load = 1'b0;
		endcase
		ctl.cut_rst = acc && last_byte && !ctl.lit_load && !ctl.cp_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flag_q  <= '0;
			first_q <= '0;
		end else begin
			phase_q <= phase_d;
			flag_q  <= flag_d;
			first_q <= first_d;
		end
	end

	// copy sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_cnt_q  <= '0;
			cp_addr_q <= '0;
			cp_last_q <= 1'b0;
		end else if (ctl.cp_start) begin
			cp_cnt_q  <= {1'b0, data_byte[3:0]} + MATCH_BIAS;
			cp_addr_q <= AW'({data_byte[7:4], first_q});
			cp_last_q <= last_byte;
		end else if (rd_en) begin
			cp_cnt_q  <= cp_cnt_q - 5'd1;
			cp_addr_q <= cp_addr_q + AW'(1);
		end
	end

	// write position and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= START_AD;
			fill_q <= '0;
		end else if (ctl.cut_rst || (s1_adv && last_s1)) begin
			wp_q   <= START_AD;
			fill_q <= '0;
		end else if (s1_adv) begin
			wp_q <= wp_q + AW'(1);
			if (fill_q != FILL_MAX) begin
				fill_q <= fill_q + (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			win_mem[wp_q] <= s1_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= win_mem[cp_addr_q];
		end
	end

	// data stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rd_en || ctl.lit_load) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			src_s1  <= hit ? SRC_HELD : (filled ? SRC_RAM : SRC_FILL);
			byte_s1 <= s1_data;
			last_s1 <= cp_last_q && (cp_cnt_q == 5'd1);
		end else if (ctl.lit_load) begin
			src_s1  <= SRC_HELD;
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_byte_q <= s1_data;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

>>> rtl/lzwd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lzwd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] data_byte,
	input wire logic       last_byte,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	// once reset has been seen at an edge, nothing is pending and requests are open
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("result or stall after reset");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(last_byte))
		else $error("stalled request changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(out_last))
		else $error("stalled result changed");

endmodule

bind lzss_window_decoder_unit lzwd_checker u_lzwd_checker (.*);
`default_nettype wire
